// ===== hdl/yv12c_pkg.sv =====
`default_nettype none

package yv12c_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned INDEX_W  = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] MAX_WIDTH  = 13'd4096;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd704;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd576;

  // Fixed point, 12 fraction bits. Largest magnitude sum is below 2^21.
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned ACC_W     = 22;

  localparam logic signed [ACC_W-1:0] K_RV = 22'sd5614;
  localparam logic signed [ACC_W-1:0] K_GU = 22'sd2859;
  localparam logic signed [ACC_W-1:0] K_GV = 22'sd2880;
  localparam logic signed [ACC_W-1:0] K_BU = 22'sd7096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } frame_dims_t;

  // Floor (drop fraction) then clamp to 0..255.
  function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic signed [ACC_W-1:0] acc);
    logic [SAMPLE_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (acc[ACC_W-2]) begin
      res = '1;
    end else begin
      res = acc[FRAC_BITS +: SAMPLE_W];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/yv12_to_rgb24_pixel_convert_unit.sv =====
`default_nettype none

// Channel | Handshake            | Word
// --------+----------------------+--------------------------------------------
// in      | in_valid / in_ready  | luma, chroma_u, chroma_v, column, line
// out     | out_valid / out_ready| red, green, blue, dest_index
// cfg     | cfg_valid / cfg_ready| cfg_index (0 width, 1 height), cfg_data
//
// One pixel per clock sustained while out_ready is high. Pipeline is an input
// register, then conversion and index multiply feeding the output register, which
// sets out_valid. A stall at out_ready backs up through both registers.
// Synchronous reset clears both valid flags and loads width 704, height 576.
// cfg_ready is always high; cfg writes land on the next edge.

module yv12_to_rgb24_pixel_convert_unit
  import yv12c_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SAMPLE_W-1:0]  luma,
  input  wire logic [SAMPLE_W-1:0]  chroma_u,
  input  wire logic [SAMPLE_W-1:0]  chroma_v,
  input  wire logic [POS_W-1:0]     column,
  input  wire logic [POS_W-1:0]     line,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [SAMPLE_W-1:0]       red,
  output logic [SAMPLE_W-1:0]       green,
  output logic [SAMPLE_W-1:0]       blue,
  output logic [INDEX_W-1:0]        dest_index,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  frame_dims_t dims;

  // input register
  logic                stage_valid;
  logic [SAMPLE_W-1:0] stage_luma;
  logic [SAMPLE_W-1:0] stage_u;
  logic [SAMPLE_W-1:0] stage_v;
  logic [POS_W-1:0]    stage_column;
  logic [POS_W-1:0]    stage_line;

  logic                out_load;
  logic                stage_load;
  logic [SAMPLE_W-1:0] red_next;
  logic [SAMPLE_W-1:0] green_next;
  logic [SAMPLE_W-1:0] blue_next;
  logic [INDEX_W-1:0]  dest_index_next;

  assign cfg_ready  = 1'b1;
  assign out_load   = !out_valid || out_ready;
  assign in_ready   = !stage_valid || out_load;
  assign stage_load = in_valid && in_ready;

  yv12c_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dims      (dims)
  );

  yv12c_color u_color (
    .luma     (stage_luma),
    .chroma_u (stage_u),
    .chroma_v (stage_v),
    .red      (red_next),
    .green    (green_next),
    .blue     (blue_next)
  );

  yv12c_index u_index (
    .dims       (dims),
    .column     (stage_column),
    .line       (stage_line),
    .dest_index (dest_index_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load) begin
      stage_luma   <= luma;
      stage_u      <= chroma_u;
      stage_v      <= chroma_v;
      stage_column <= column;
      stage_line   <= line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && stage_valid) begin
      red        <= red_next;
      green      <= green_next;
      blue       <= blue_next;
      dest_index <= dest_index_next;
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    stage_load |=> stage_valid)
    else $error("accepted word did not reach the input register");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !out_load |=> stage_valid && $stable(stage_luma) && $stable(stage_line))
    else $error("input register changed while output stalled");

  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    stage_valid && out_load |=> out_valid)
    else $error("word lost between input and output register");

  a_width_sat: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && (cfg_index == CFG_FRAME_WIDTH) && (cfg_data > MAX_WIDTH)
    |=> dims.width == MAX_WIDTH)
    else $error("frame width not saturated");

endmodule

`default_nettype wire

// ===== hdl/yv12c_cfg.sv =====
`default_nettype none

module yv12c_cfg
  import yv12c_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  output frame_dims_t               dims
);

  logic [DIM_W-1:0] width_sat;
  logic [DIM_W-1:0] height_sat;

  assign width_sat  = (cfg_data > MAX_WIDTH)  ? MAX_WIDTH  : cfg_data;
  assign height_sat = (cfg_data > MAX_HEIGHT) ? MAX_HEIGHT : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.width  <= RESET_WIDTH;
      dims.height <= RESET_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  dims.width  <= width_sat;
        CFG_FRAME_HEIGHT: dims.height <= height_sat;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/yv12c_color.sv =====
`default_nettype none

module yv12c_color
  import yv12c_pkg::*;
(
  input  wire logic [SAMPLE_W-1:0] luma,
  input  wire logic [SAMPLE_W-1:0] chroma_u,
  input  wire logic [SAMPLE_W-1:0] chroma_v,
  output logic [SAMPLE_W-1:0]      red,
  output logic [SAMPLE_W-1:0]      green,
  output logic [SAMPLE_W-1:0]      blue
);

  logic signed [SAMPLE_W-1:0] du;
  logic signed [SAMPLE_W-1:0] dv;
  logic signed [ACC_W-1:0]    du_ext;
  logic signed [ACC_W-1:0]    dv_ext;
  logic signed [ACC_W-1:0]    base;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_g;
  logic signed [ACC_W-1:0]    acc_b;

  // x - 128 for an 8-bit sample is the sample with its top bit flipped, as signed
  assign du = $signed({~chroma_u[SAMPLE_W-1], chroma_u[SAMPLE_W-2:0]});
  assign dv = $signed({~chroma_v[SAMPLE_W-1], chroma_v[SAMPLE_W-2:0]});
  assign du_ext = ACC_W'(du);
  assign dv_ext = ACC_W'(dv);
  assign base = $signed({{(ACC_W-SAMPLE_W-FRAC_BITS){1'b0}}, luma, {FRAC_BITS{1'b0}}});

  assign acc_r = base + K_RV * dv_ext;
  assign acc_g = base - K_GU * du_ext - K_GV * dv_ext;
  assign acc_b = base + K_BU * du_ext;

  assign red   = clamp_sample(acc_r);
  assign green = clamp_sample(acc_g);
  assign blue  = clamp_sample(acc_b);

endmodule

`default_nettype wire

// ===== hdl/yv12c_index.sv =====
`default_nettype none

module yv12c_index
  import yv12c_pkg::*;
(
  input  wire frame_dims_t        dims,
  input  wire logic [POS_W-1:0]   column,
  input  wire logic [POS_W-1:0]   line,
  output logic [INDEX_W-1:0]      dest_index
);

  logic [INDEX_W-1:0] flipped;
  logic [INDEX_W-1:0] row_base;

  // all arithmetic wraps modulo 2^24
  assign flipped    = INDEX_W'(dims.height) - INDEX_W'(1) - INDEX_W'(line);
  assign row_base   = INDEX_W'(flipped * INDEX_W'(dims.width));
  assign dest_index = row_base + INDEX_W'(column);

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import yv12c_pkg::*;

  localparam int COEF_RED_V   = 5614;
  localparam int COEF_GREEN_U = 2859;
  localparam int COEF_GREEN_V = 2880;
  localparam int COEF_BLUE_U  = 7096;
  localparam int CHROMA_ZERO  = 128;
  localparam int FRAC_SHIFT   = 12;
  localparam int SAMPLE_MAX   = 255;
  localparam int DIM_LIMIT    = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam int SETTLE      = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] chroma_u;
    logic [SAMPLE_W-1:0] chroma_v;
    logic [POS_W-1:0]    column;
    logic [POS_W-1:0]    line;
  } pixel_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [INDEX_W-1:0]  dest_index;
  } pixel_out_t;

  class pixel_scoreboard;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    pixel_out_t       rgb_queue[$];
    int unsigned      mismatches;

    function new();
      width      = 13'd704;
      height     = 13'd576;
      mismatches = 0;
    endfunction

    function int pending();
      return rgb_queue.size();
    endfunction

    task report(input string msg);
      $display("testbench: mismatch: %s", msg);
      mismatches++;
    endtask

    // Values above the maximum saturate; unknown indexes are dropped.
    function void note_config(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
      logic [DIM_W-1:0] sat;
      sat = (data > DIM_LIMIT) ? DIM_W'(DIM_LIMIT) : data;
      case (idx)
        CFG_FRAME_WIDTH: begin
          width = sat;
        end
        CFG_FRAME_HEIGHT: begin
          height = sat;
        end
        default: begin
        end
      endcase
    endfunction

    function logic [SAMPLE_W-1:0] floor_clamp(input int acc);
      int whole;
      if (acc < 0) begin
        return '0;
      end
      whole = acc >>> FRAC_SHIFT;
      return (whole > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(whole);
    endfunction

    function pixel_out_t convert(input pixel_in_t p);
      int         base;
      int         du;
      int         dv;
      bit [31:0]  rows_below;
      bit [47:0]  flat;
      pixel_out_t r;
      base = int'(p.luma) * (1 << FRAC_SHIFT);
      du   = int'(p.chroma_u) - CHROMA_ZERO;
      dv   = int'(p.chroma_v) - CHROMA_ZERO;
      r.red   = floor_clamp(base + COEF_RED_V * dv);
      r.green = floor_clamp(base - COEF_GREEN_U * du - COEF_GREEN_V * dv);
      r.blue  = floor_clamp(base + COEF_BLUE_U * du);
      // flip wraps modulo 2^24 when line is outside the frame
      rows_below = {19'd0, height} - 32'd1 - {20'd0, p.line};
      flat = {24'd0, rows_below[23:0]} * {35'd0, width} + {36'd0, p.column};
      r.dest_index = flat[INDEX_W-1:0];
      return r;
    endfunction

    function void note_pixel(input pixel_in_t p);
      rgb_queue.push_back(convert(p));
    endfunction

    task check_pixel(input pixel_out_t got);
      pixel_out_t want;
      if (rgb_queue.size() == 0) begin
        report($sformatf("unexpected word r=%0d g=%0d b=%0d idx=%0d",
                         got.red, got.green, got.blue, got.dest_index));
      end else begin
        want = rgb_queue.pop_front();
        if (got.red !== want.red)
          report($sformatf("red got %0d want %0d", got.red, want.red));
        if (got.green !== want.green)
          report($sformatf("green got %0d want %0d", got.green, want.green));
        if (got.blue !== want.blue)
          report($sformatf("blue got %0d want %0d", got.blue, want.blue));
        if (got.dest_index !== want.dest_index)
          report($sformatf("dest_index got %0d want %0d", got.dest_index, want.dest_index));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  luma      = '0;
  logic [SAMPLE_W-1:0]  chroma_u  = '0;
  logic [SAMPLE_W-1:0]  chroma_v  = '0;
  logic [POS_W-1:0]     column    = '0;
  logic [POS_W-1:0]     line      = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SAMPLE_W-1:0]  red;
  logic [SAMPLE_W-1:0]  green;
  logic [SAMPLE_W-1:0]  blue;
  logic [INDEX_W-1:0]   dest_index;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  pixel_scoreboard sb;
  bit              steady = 1'b0;
  int unsigned     cycle_count = 0;

  yv12_to_rgb24_pixel_convert_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .luma       (luma),
    .chroma_u   (chroma_u),
    .chroma_v   (chroma_v),
    .column     (column),
    .line       (line),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .dest_index (dest_index),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  task send_pixel(input pixel_in_t p);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    luma     <= p.luma;
    chroma_u <= p.chroma_u;
    chroma_v <= p.chroma_v;
    column   <= p.column;
    line     <= p.line;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(p);
  endtask

  task send_fields(input int l, input int u, input int v, input int c, input int r);
    pixel_in_t p;
    p.luma     = SAMPLE_W'(l);
    p.chroma_u = SAMPLE_W'(u);
    p.chroma_v = SAMPLE_W'(v);
    p.column   = POS_W'(c);
    p.line     = POS_W'(r);
    send_pixel(p);
  endtask

  // cfg_valid stays high across back-to-back writes; caller lowers it
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
  endtask

  function logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'(CHROMA_ZERO);
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly inside the frame, sometimes anywhere in the 12-bit range
  function logic [POS_W-1:0] pick_position(input logic [DIM_W-1:0] dim);
    if (dim == 0 || $urandom_range(0, 4) == 0) begin
      return POS_W'($urandom_range(0, 4095));
    end
    return POS_W'($urandom_range(0, int'(dim) - 1));
  endfunction

  task random_run(input int count);
    pixel_in_t p;
    for (int i = 0; i < count; i++) begin
      p.luma     = pick_sample();
      p.chroma_u = pick_sample();
      p.chroma_v = pick_sample();
      p.column   = pick_position(sb.width);
      p.line     = pick_position(sb.height);
      send_pixel(p);
    end
  endtask

  task wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    pixel_out_t got;
    int         stall;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.red        = red;
      got.green      = green;
      got.blue       = blue;
      got.dest_index = dest_index;
      sb.check_pixel(got);
    end
  end

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset frame size 704x576: extremes, gray, saturating chroma, edges of the frame
    send_fields(0, 0, 0, 0, 0);
    send_fields(255, 255, 255, 4095, 4095);
    send_fields(0, 128, 128, 0, 575);
    send_fields(255, 128, 128, 703, 0);
    send_fields(128, 128, 128, 703, 575);
    send_fields(255, 0, 0, 100, 200);
    send_fields(0, 255, 255, 5, 6);
    send_fields(0, 0, 255, 7, 8);
    send_fields(255, 255, 0, 9, 10);
    send_fields(128, 0, 255, 11, 12);
    send_fields(128, 255, 0, 13, 14);
    send_fields(16, 128, 128, 1, 1);
    send_fields(235, 240, 16, 2, 3);
    send_fields(60, 90, 200, 0, 576);
    send_fields(200, 30, 170, 704, 10);
    send_fields(1, 127, 129, 300, 300);
    send_fields(254, 129, 127, 400, 100);
    send_fields(0, 0, 0, 4095, 0);
    send_fields(255, 255, 255, 0, 4095);
    send_fields(77, 200, 50, 2048, 2048);
    random_run(PHASE_ITEMS);

    // 2x1 frame
    wait_for_results();
    write_reg(CFG_FRAME_WIDTH, 13'd2);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    cfg_valid <= 1'b0;
    random_run(PHASE_ITEMS);

    // all-ones writes saturate to the maximum; first half at full rate
    wait_for_results();
    write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    cfg_valid <= 1'b0;
    steady = 1'b1;
    random_run(PHASE_ITEMS / 2);
    steady = 1'b0;
    random_run(PHASE_ITEMS / 2);

    // zero size, then writes to unused indexes that must not stick
    wait_for_results();
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    write_reg(CFG_SPARE_2, 13'h1555);
    write_reg(CFG_SPARE_3, 13'h0AAA);
    cfg_valid <= 1'b0;
    random_run(PHASE_ITEMS);

    // exact maximum and one past it
    wait_for_results();
    write_reg(CFG_FRAME_WIDTH, 13'd4096);
    write_reg(CFG_FRAME_HEIGHT, 13'd4097);
    cfg_valid <= 1'b0;
    random_run(PHASE_ITEMS);

    // random size, with a full drain in the middle
    wait_for_results();
    write_reg(CFG_FRAME_HEIGHT, DIM_W'($urandom_range(1, 4096)));
    write_reg(CFG_FRAME_WIDTH, DIM_W'($urandom_range(2, 8191)));
    cfg_valid <= 1'b0;
    random_run(PHASE_ITEMS / 2);
    wait_for_results();
    random_run(PHASE_ITEMS / 2);

    wait_for_results();
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d words never arrived", sb.pending()));
    end
    if (sb.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
